// ===== hw/rtl/bitmap_frame_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Bitmap frame allocator assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bfa assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bfa assertion failed");

`endif

// ===== hw/rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Types and fixed constants shared by the bitmap frame allocator modules.
// ----------------------------------------------------------------------------
package bfa_pkg;

	// fixed field widths of the request and response
	localparam int FRAME_FIELD_W = 15;
	localparam int ADDR_FIELD_W  = 27;

	// opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// request payload
	typedef struct packed {
		logic                     opcode;
		logic [FRAME_FIELD_W-1:0] frame_to_free;
	} bfa_req_t;

	// response payload
	typedef struct packed {
		logic [FRAME_FIELD_W-1:0] granted_frame;
		logic [ADDR_FIELD_W-1:0]  phys_address;
		logic                     out_of_memory;
	} bfa_rsp_t;

	// bitmap memory command strobes
	typedef struct packed {
		logic rd;
		logic wr;
	} bfa_mem_cmd_t;

endpackage

// ===== hw/rtl/bfa_map_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_map_ram
// Used/free bitmap storage: one write port, one registered read port, and a
// sweep after reset that sets every word to all-used.
// ----------------------------------------------------------------------------
module bfa_map_ram import bfa_pkg::*; #(
	parameter int MAP_WORDS = 1024,
	parameter int WORD_BITS = 32,
	parameter int WADDR_W   = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bfa_mem_cmd_t         cmd,
	input  logic [WADDR_W-1:0]   rd_addr,
	input  logic [WADDR_W-1:0]   wr_addr,
	input  logic [WORD_BITS-1:0] wr_data,
	output logic [WORD_BITS-1:0] rd_data,
	output logic                 busy
);

	localparam logic [WADDR_W-1:0] WORD_LAST = WADDR_W'(MAP_WORDS - 1);

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rd_data_q;
	logic [WADDR_W-1:0]   clr_addr_q;
	logic                 clr_busy_q;
	logic                 wr_en;
	logic [WADDR_W-1:0]   wr_idx;
	logic [WORD_BITS-1:0] wr_word;

	// clearing sweep: one word per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_addr_q == WORD_LAST) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// write port shared between sweep and engine
	always_comb begin
		wr_en   = clr_busy_q | cmd.wr;
		wr_idx  = clr_busy_q ? clr_addr_q : wr_addr;
		wr_word = clr_busy_q ? '1 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_word;
		end
	end

	// registered read, holds until the next read
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_busy_q;

endmodule

// ===== hw/rtl/bfa_ptr.sv =====
// ----------------------------------------------------------------------------
// bfa_ptr
// Roving search pointer. A first_frame write is reduced modulo the frame
// count by reciprocal multiplication, quotient then remainder, before the
// pointer is usable.
// ----------------------------------------------------------------------------
module bfa_ptr import bfa_pkg::*; #(
	parameter int NUM_FRAMES = 32768,
	parameter int FRAME_W    = 15
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [FRAME_FIELD_W-1:0] cfg_data,
	input  logic                     load,
	input  logic [FRAME_W-1:0]       load_value,
	output logic [FRAME_W-1:0]       ptr,
	output logic                     busy
);

	// reciprocal of NUM_FRAMES, exact quotient for every 15-bit dividend
	localparam int RCP_S  = FRAME_FIELD_W + FRAME_W;
	localparam int RCP_W  = FRAME_FIELD_W + 2;
	localparam int PROD_W = FRAME_FIELD_W + RCP_W;
	localparam longint unsigned RCP_M =
		((64'd1 << RCP_S) + 64'(NUM_FRAMES) - 64'd1) / 64'(NUM_FRAMES);
	localparam logic [RCP_W-1:0]         RCP_C = RCP_W'(RCP_M);
	localparam logic [FRAME_FIELD_W-1:0] NF_V  = FRAME_FIELD_W'(NUM_FRAMES);

	// reduction steps
	localparam logic [1:0] CNT_QUO = 2'd2;
	localparam logic [1:0] CNT_REM = 2'd1;

	logic [FRAME_W-1:0]       ptr_q;
	logic [FRAME_FIELD_W-1:0] val_q;
	logic [FRAME_FIELD_W-1:0] quo_q;
	logic [1:0]               cnt_q;
	logic [PROD_W-1:0]        prod;
	logic [FRAME_FIELD_W-1:0] quo;
	logic [FRAME_FIELD_W-1:0] rem;
	logic                     cfg_wr;

	assign busy      = (cnt_q != '0);
	assign cfg_ready = ~busy;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// quotient by reciprocal, then remainder from the registered quotient
	always_comb begin
		prod = PROD_W'(val_q) * PROD_W'(RCP_C);
		quo  = FRAME_FIELD_W'(prod >> RCP_S);
		rem  = val_q - FRAME_FIELD_W'(quo_q * NF_V);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			val_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
		end else if (cfg_wr) begin
			val_q <= cfg_data;
			cnt_q <= CNT_QUO;
		end else if (cnt_q == CNT_QUO) begin
			quo_q <= quo;
			cnt_q <= CNT_REM;
		end else if (cnt_q == CNT_REM) begin
			ptr_q <= FRAME_W'(rem);
			cnt_q <= '0;
		end else if (load) begin
			ptr_q <= load_value;
		end
	end

	assign ptr = ptr_q;

endmodule

// ===== hw/rtl/bfa_engine.sv =====
`include "bitmap_frame_allocator_macros.svh"
// ----------------------------------------------------------------------------
// bfa_engine
// Request sequencer: reads bitmap words, scans for a free frame next-fit
// from the pointer, and writes the modified word back.
// ----------------------------------------------------------------------------
module bfa_engine import bfa_pkg::*; #(
	parameter int NUM_FRAMES = 32768,
	parameter int PAGE_SHIFT = 12,
	parameter int WORD_BITS  = 32,
	parameter int FRAME_W    = 15,
	parameter int MAP_WORDS  = 1024,
	parameter int WADDR_W    = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_stall,
	input  bfa_req_t             req,
	// completion toward the response register
	input  logic                 out_free,
	output logic                 done,
	output bfa_rsp_t             rsp,
	// pointer
	input  logic [FRAME_W-1:0]   ptr,
	input  logic                 ptr_busy,
	output logic                 ptr_load,
	output logic [FRAME_W-1:0]   ptr_value,
	// bitmap memory
	input  logic                 ram_busy,
	output bfa_mem_cmd_t         cmd,
	output logic [WADDR_W-1:0]   rd_addr,
	output logic [WADDR_W-1:0]   wr_addr,
	output logic [WORD_BITS-1:0] wr_data,
	input  logic [WORD_BITS-1:0] rd_data
);

	localparam int BIT_W  = $clog2(WORD_BITS);
	localparam int SCAN_W = $clog2(MAP_WORDS + 1);
	localparam logic [SCAN_W-1:0]  SCAN_LAST = SCAN_W'(MAP_WORDS);
	localparam logic [WADDR_W-1:0] WORD_LAST = WADDR_W'(MAP_WORDS - 1);
	localparam logic [FRAME_W:0]   NF_C      = (FRAME_W + 1)'(NUM_FRAMES);
	localparam logic [31:0]        NF_32     = 32'(NUM_FRAMES);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EVAL = 1'b1;

	logic                 state_q;
	logic                 op_q;
	logic                 tgt_ok_q;
	logic [WADDR_W-1:0]   word_q;
	logic [BIT_W-1:0]     bit0_q;
	logic [SCAN_W-1:0]    scan_q;

	logic                 req_acc;
	logic [WADDR_W-1:0]   start_word;
	logic [BIT_W-1:0]     start_bit;
	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] scan_mask;
	logic [WORD_BITS-1:0] cand;
	logic                 found;
	logic [BIT_W-1:0]     idx;
	logic [FRAME_W-1:0]   grant;
	logic [FRAME_W:0]     grant_inc;
	logic                 step_next;
	logic [WADDR_W-1:0]   next_word;

	// accept only when idle, swept and pointer settled
	assign req_stall = (state_q != ST_IDLE) | ram_busy | ptr_busy;
	assign req_acc   = req_valid & ~req_stall;

	// first word and bit of the request
	always_comb begin
		if (req.opcode == OP_FREE) begin
			start_word = WADDR_W'(req.frame_to_free >> BIT_W);
			start_bit  = BIT_W'(req.frame_to_free);
		end else begin
			start_word = WADDR_W'(ptr >> BIT_W);
			start_bit  = BIT_W'(ptr);
		end
	end

	// candidate bits of the current word; first and last visit are partial
	always_comb begin
		lo_mask = '1 << bit0_q;
		if (scan_q == '0) begin
			scan_mask = lo_mask;
		end else if (scan_q == SCAN_LAST) begin
			scan_mask = ~lo_mask;
		end else begin
			scan_mask = '1;
		end
		cand  = ~rd_data & scan_mask;
		found = |cand;
	end

	// lowest free bit
	always_comb begin
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				idx = BIT_W'(i);
			end
		end
	end

	// granted frame and the pointer after it
	always_comb begin
		grant     = FRAME_W'({word_q, idx});
		grant_inc = {1'b0, grant} + 1'b1;
		ptr_value = (grant_inc == NF_C) ? '0 : FRAME_W'(grant_inc);
		next_word = (word_q == WORD_LAST) ? '0 : word_q + 1'b1;
	end

	// memory commands, completion and response
	always_comb begin
		cmd       = '0;
		rd_addr   = req_acc ? start_word : next_word;
		wr_addr   = word_q;
		wr_data   = rd_data;
		done      = 1'b0;
		rsp       = '0;
		ptr_load  = 1'b0;
		step_next = 1'b0;
		if (req_acc) begin
			cmd.rd = 1'b1;
		end
		if (state_q == ST_EVAL) begin
			if (op_q == OP_FREE) begin
				wr_data = rd_data & ~(WORD_BITS'(1) << bit0_q);
				cmd.wr  = tgt_ok_q & out_free;
				done    = out_free;
			end else if (found) begin
				wr_data                 = rd_data | (WORD_BITS'(1) << idx);
				cmd.wr                  = out_free;
				done                    = out_free;
				ptr_load                = out_free;
				rsp.granted_frame       = FRAME_FIELD_W'(grant);
				rsp.phys_address        = ADDR_FIELD_W'({grant, {PAGE_SHIFT{1'b0}}});
			end else if (scan_q == SCAN_LAST) begin
				done              = out_free;
				rsp.out_of_memory = 1'b1;
			end else begin
				cmd.rd    = 1'b1;
				step_next = 1'b1;
			end
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q     <= req.opcode;
			tgt_ok_q <= ({17'd0, req.frame_to_free} < NF_32);
			word_q   <= start_word;
			bit0_q   <= start_bit;
			scan_q   <= '0;
		end else if (step_next) begin
			word_q <= next_word;
			scan_q <= scan_q + 1'b1;
		end
	end

	`BFA_ASSERT_IMP(a_no_req_while_sweep, clk, arst_n, req_acc, !ram_busy && !ptr_busy)
	`BFA_ASSERT_IMP(a_wr_only_in_eval, clk, arst_n, cmd.wr, state_q == ST_EVAL && out_free)
	`BFA_ASSERT_IMP(a_scan_bounded, clk, arst_n, state_q == ST_EVAL, scan_q <= SCAN_LAST)
	`BFA_ASSERT_NXT(a_grant_ends_item, clk, arst_n, ptr_load, state_q == ST_IDLE)
	`BFA_ASSERT_IMP(a_oom_no_write, clk, arst_n, done && rsp.out_of_memory, !cmd.wr && !ptr_load)

endmodule

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Next-fit page-frame allocator over a used/free bitmap held in one
// synchronous memory of WORD_BITS-bit words.
// ----------------------------------------------------------------------------
// One request at a time. A free reads its word and then writes it back. An
// allocate reads bitmap words, one word per cycle through the single read
// port, until a free bit turns up; a failed search reads every word plus
// the start word again. After reset the bitmap is swept to all-used, one
// word per cycle, and no request is taken until it ends. A first_frame
// write is reduced modulo NUM_FRAMES, quotient then remainder; meanwhile
// cfg_ready and requests are held off. WORD_BITS must be a power of two.
// The response register lets a new request in while a result waits.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator import bfa_pkg::*; #(
	parameter int NUM_FRAMES = 32768,
	parameter int PAGE_SHIFT = 12,
	parameter int WORD_BITS  = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [FRAME_FIELD_W-1:0] cfg_data,
	// request channel
	input  logic                     req_valid,
	output logic                     req_stall,
	input  bfa_req_t                 req,
	// response channel
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output bfa_rsp_t                 rsp
);

	localparam int FRAME_W   = $clog2(NUM_FRAMES);
	localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	bfa_mem_cmd_t         mem_cmd;
	logic [WADDR_W-1:0]   mem_rd_addr;
	logic [WADDR_W-1:0]   mem_wr_addr;
	logic [WORD_BITS-1:0] mem_wr_data;
	logic [WORD_BITS-1:0] mem_rd_data;
	logic                 mem_busy;

	logic [FRAME_W-1:0]   ptr;
	logic                 ptr_busy;
	logic                 ptr_load;
	logic [FRAME_W-1:0]   ptr_value;

	logic                 eng_done;
	bfa_rsp_t             eng_rsp;
	logic                 out_free;

	logic                 rsp_valid_q;
	bfa_rsp_t             rsp_q;

	bfa_map_ram #(
		.MAP_WORDS (MAP_WORDS),
		.WORD_BITS (WORD_BITS),
		.WADDR_W   (WADDR_W)
	) u_map_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (mem_cmd),
		.rd_addr (mem_rd_addr),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_data (mem_rd_data),
		.busy    (mem_busy)
	);

	bfa_ptr #(
		.NUM_FRAMES (NUM_FRAMES),
		.FRAME_W    (FRAME_W)
	) u_ptr (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.load       (ptr_load),
		.load_value (ptr_value),
		.ptr        (ptr),
		.busy       (ptr_busy)
	);

	bfa_engine #(
		.NUM_FRAMES (NUM_FRAMES),
		.PAGE_SHIFT (PAGE_SHIFT),
		.WORD_BITS  (WORD_BITS),
		.FRAME_W    (FRAME_W),
		.MAP_WORDS  (MAP_WORDS),
		.WADDR_W    (WADDR_W)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.out_free  (out_free),
		.done      (eng_done),
		.rsp       (eng_rsp),
		.ptr       (ptr),
		.ptr_busy  (ptr_busy),
		.ptr_load  (ptr_load),
		.ptr_value (ptr_value),
		.ram_busy  (mem_busy),
		.cmd       (mem_cmd),
		.rd_addr   (mem_rd_addr),
		.wr_addr   (mem_wr_addr),
		.wr_data   (mem_wr_data),
		.rd_data   (mem_rd_data)
	);

	// response register: free when empty or being taken this cycle
	assign out_free = ~rsp_valid_q | ~rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (eng_done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done) begin
			rsp_q <= eng_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== sim/bitmap_frame_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_tb
// Drives allocate and free requests into the frame allocator, tracks its own
// copy of the used/free bitmap and next-fit pointer, and checks every
// response field against the grant it predicts, in order of acceptance.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_tb import bfa_pkg::*;;

	localparam int NUM_FRAMES  = 32768;
	localparam int PAGE_SHIFT  = 12;
	localparam int WORD_BITS   = 32;
	localparam int MAP_WORDS   = NUM_FRAMES / WORD_BITS;
	localparam int PHASE_ITEMS = 160;
	localparam int NUM_PHASES  = 5;
	localparam int HOLD_AT     = 300;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN_TAIL  = MAP_WORDS + 16;
	localparam longint unsigned CYCLE_LIMIT = 4_000_000;

	// Tracks the bitmap and search pointer, predicts each grant.
	class frame_map_tracker;
		logic [WORD_BITS-1:0]     used_words [MAP_WORDS];
		logic [FRAME_FIELD_W-1:0] search_ptr;
		logic [FRAME_FIELD_W-1:0] first_frame;
		int unsigned              free_frames;
		int unsigned              errors;
		bfa_rsp_t                 expected_grants [$];

		function new();
			foreach (used_words[w]) begin
				used_words[w] = '1;
			end
			search_ptr  = '0;
			first_frame = '0;
			free_frames = 0;
			errors      = 0;
		endfunction

		function bit frame_used(int f);
			return used_words[f / WORD_BITS][f % WORD_BITS];
		endfunction

		function void set_first_frame(logic [FRAME_FIELD_W-1:0] value);
			first_frame = value;
			search_ptr  = FRAME_FIELD_W'(int'(value) % NUM_FRAMES);
		endfunction

		function int unsigned pending();
			return expected_grants.size();
		endfunction

		// work out the response for one accepted request
		function void note_request(bfa_req_t r);
			bfa_rsp_t grant;
			int       f;
			int       n;
			bit       found;
			grant = '0;
			found = 1'b0;
			if (r.opcode == OP_FREE) begin
				f = int'(r.frame_to_free);
				if (f < NUM_FRAMES) begin
					if (frame_used(f)) begin
						free_frames++;
					end
					used_words[f / WORD_BITS][f % WORD_BITS] = 1'b0;
				end
			end else begin
				// next-fit scan, wrapping at the end of the map
				f = int'(search_ptr) % NUM_FRAMES;
				for (n = 0; n < NUM_FRAMES && !found; n++) begin
					if (!frame_used(f)) begin
						found = 1'b1;
					end else begin
						f = (f + 1) % NUM_FRAMES;
					end
				end
				if (found) begin
					used_words[f / WORD_BITS][f % WORD_BITS] = 1'b1;
					free_frames--;
					grant.granted_frame = FRAME_FIELD_W'(f);
					grant.phys_address  = ADDR_FIELD_W'(longint'(f) << PAGE_SHIFT);
					search_ptr          = FRAME_FIELD_W'((f + 1) % NUM_FRAMES);
				end else begin
					grant.out_of_memory = 1'b1;
				end
			end
			expected_grants.push_back(grant);
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		// compare one accepted response with the oldest prediction
		task check_response(bfa_rsp_t got);
			bfa_rsp_t want;
			if (expected_grants.size() == 0) begin
				report("response with no request outstanding");
				return;
			end
			want = expected_grants.pop_front();
			if (got.granted_frame !== want.granted_frame) begin
				report($sformatf("granted_frame got %0d want %0d",
					got.granted_frame, want.granted_frame));
			end
			if (got.phys_address !== want.phys_address) begin
				report($sformatf("phys_address got 0x%0h want 0x%0h",
					got.phys_address, want.phys_address));
			end
			if (got.out_of_memory !== want.out_of_memory) begin
				report($sformatf("out_of_memory got %0b want %0b",
					got.out_of_memory, want.out_of_memory));
			end
		endtask
	endclass

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [FRAME_FIELD_W-1:0] cfg_data  = '0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	bfa_req_t                 req       = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	bfa_rsp_t                 rsp;

	frame_map_tracker  frame_map = new();
	bit                idle_on   = 1'b1;
	int unsigned       sent      = 0;
	longint unsigned   cycle_count = 0;

	bitmap_frame_allocator #(
		.NUM_FRAMES(NUM_FRAMES),
		.PAGE_SHIFT(PAGE_SHIFT),
		.WORD_BITS(WORD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("bitmap_frame_allocator_tb NOT OK");
			$finish;
		end
	end

	// idle length: mostly short, now and then long
	function automatic int unsigned gap_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Offer one request and hold it until accepted. Entered and left at a
	// falling edge; valid stays high on return so back-to-back requests
	// never toggle it within one step.
	task automatic send_request(input bfa_req_t r);
		int unsigned gap;
		gap = idle_on ? gap_len() : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (req_stall);
		frame_map.note_request(r);
		sent++;
		@(negedge clk);
	endtask

	task automatic request_alloc();
		bfa_req_t r;
		r.opcode        = OP_ALLOC;
		r.frame_to_free = FRAME_FIELD_W'($urandom_range(0, NUM_FRAMES - 1));
		send_request(r);
	endtask

	task automatic request_free(input logic [FRAME_FIELD_W-1:0] f);
		bfa_req_t r;
		r.opcode        = OP_FREE;
		r.frame_to_free = f;
		send_request(r);
	endtask

	// an allocate with nothing free scans the whole map, so keep those rare
	task automatic maybe_alloc();
		if (frame_map.free_frames != 0 || $urandom_range(0, 39) == 0) begin
			request_alloc();
		end
	endtask

	// stop offering and wait for every outstanding response
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (frame_map.pending() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_first_frame(input logic [FRAME_FIELD_W-1:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		frame_map.set_first_frame(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// response side: random stalls plus one long hold-off
	initial begin : rsp_side
		int unsigned stall_left;
		int unsigned seen;
		bit          held;
		stall_left = 0;
		seen       = 0;
		held       = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				frame_map.check_response(rsp);
				seen++;
			end
			@(negedge clk);
			if (!held && seen >= HOLD_AT) begin
				held       = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left != 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
				if (idle_on && $urandom_range(0, 2) == 0) begin
					stall_left = gap_len();
				end
			end
		end
	end

	// request side and verdict
	initial begin : req_side
		logic [FRAME_FIELD_W-1:0] cfg_values [NUM_PHASES];
		logic [FRAME_FIELD_W-1:0] base;
		int                       p;
		int                       i;
		int                       kind;
		int                       nfree;
		int                       nalloc;

		cfg_values[0] = '0;
		cfg_values[1] = '1;
		cfg_values[2] = FRAME_FIELD_W'($urandom_range(0, NUM_FRAMES - 1));
		cfg_values[3] = FRAME_FIELD_W'(NUM_FRAMES / 2);
		cfg_values[4] = FRAME_FIELD_W'($urandom_range(0, NUM_FRAMES - 1));

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// map starts all used: allocate fails
		request_alloc();
		// both ends of the map, a double free, then the pointer wraps
		request_free('0);
		request_free('1);
		request_free('1);
		request_alloc();
		request_alloc();
		request_alloc();

		// pointer loaded at the last frame: grant there, then wrap to the front
		wait_drained();
		write_first_frame('1);
		request_free(FRAME_FIELD_W'(5));
		request_free('1);
		request_alloc();
		request_alloc();
		request_free(FRAME_FIELD_W'('h5555));
		request_free(FRAME_FIELD_W'('h2aaa));
		request_alloc();
		request_alloc();
		// search runs off the end and comes round to low frames
		request_free(FRAME_FIELD_W'(100));
		request_free(FRAME_FIELD_W'(101));
		request_alloc();
		request_alloc();

		// random phases, each from a fresh pointer setting
		for (p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			write_first_frame(cfg_values[p]);
			idle_on = (p != 2);
			i = sent + PHASE_ITEMS;
			while (sent < i) begin
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					// release a few frames just ahead of the pointer, then take some
					nfree = $urandom_range(1, 8);
					base  = frame_map.search_ptr + FRAME_FIELD_W'($urandom_range(0, 300));
					repeat (nfree) begin
						request_free(base + FRAME_FIELD_W'($urandom_range(0, 63)));
					end
					nalloc = $urandom_range(1, nfree + 2);
					repeat (nalloc) begin
						maybe_alloc();
					end
				end else if (kind < 9) begin
					request_free(FRAME_FIELD_W'($urandom_range(0, NUM_FRAMES - 1)));
				end else begin
					maybe_alloc();
				end
			end
		end

		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (frame_map.errors == 0) begin
			$display("bitmap_frame_allocator_tb OK");
		end else begin
			$display("bitmap_frame_allocator_tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_map_ram.sv
hw/rtl/bfa_ptr.sv
hw/rtl/bfa_engine.sv
hw/rtl/bitmap_frame_allocator.sv
sim/bitmap_frame_allocator_tb.sv
